@@ rtl/core/ntcti_pkg.sv @@
// ntcti_pkg: shared types, constants, lookup table and control store for
// the NTC table temperature interpolator. No dependencies.
package ntcti_pkg;

    localparam int SLOT_W     = 5;
    localparam int ENTRY_W    = 13;
    localparam int STEP_MILLI = 10000;
    localparam int LOW_MILLI  = -10000;
    localparam int FRAC_W     = 14;
    localparam int TM_W       = 20;
    localparam int SUM_W      = 21;
    localparam int PROD_W     = 37;
    localparam int DVSR_W     = 14;
    localparam int DIV_STEPS  = FRAC_W;
    localparam int DVND_W     = DVSR_W + DIV_STEPS;
    localparam int CNT_W      = 5;
    localparam int UPC_W      = 4;

    // floor(x / 10000) = ((x >> 4) * RCP_MUL) >> 39 while x >> 4 stays below 2**29
    localparam int MAG_LSB   = 4;
    localparam int MAG_W     = 29;
    localparam int RCP_M_W   = 30;
    localparam int RCP_W     = MAG_W + RCP_M_W;
    localparam int RCP_SHIFT = 39;
    localparam int QUO_W     = RCP_W - RCP_SHIFT;
    localparam logic [RCP_M_W-1:0] RCP_MUL = 30'd879609303;

    localparam logic REG_TEMP_SCALE  = 1'b0;
    localparam logic REG_TEMP_OFFSET = 1'b1;

    typedef enum logic [1:0] {
        ST_INTERP   = 2'd0,
        ST_CLAMP_LO = 2'd1,
        ST_CLAMP_HI = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_LOAD      = 4'd1,
        OP_INC       = 4'd2,
        OP_STAT_HI   = 4'd3,
        OP_STAT_LO   = 4'd4,
        OP_DIV1_LOAD = 4'd5,
        OP_DIV_STEP  = 4'd6,
        OP_TM_FRAC   = 4'd7,
        OP_ADD       = 4'd8,
        OP_MUL       = 4'd9,
        OP_ABS       = 4'd10,
        OP_OUT       = 4'd11,
        OP_RECIP     = 4'd12
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER       = 3'd0,
        C_ALWAYS      = 3'd1,
        C_NO_ACCEPT   = 3'd2,
        C_ABOVE_FIRST = 3'd3,
        C_FOUND       = 3'd4,
        C_NOT_LAST    = 3'd5,
        C_DIV_MORE    = 3'd6,
        C_OUT_FREE    = 3'd7
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

    localparam logic [UPC_W-1:0] A_WAIT  = 4'd0;
    localparam logic [UPC_W-1:0] A_CHK   = 4'd1;
    localparam logic [UPC_W-1:0] A_SCAN  = 4'd2;
    localparam logic [UPC_W-1:0] A_STEP  = 4'd3;
    localparam logic [UPC_W-1:0] A_CLHI  = 4'd4;
    localparam logic [UPC_W-1:0] A_CLLO  = 4'd5;
    localparam logic [UPC_W-1:0] A_D1LD  = 4'd6;
    localparam logic [UPC_W-1:0] A_D1    = 4'd7;
    localparam logic [UPC_W-1:0] A_TMF   = 4'd8;
    localparam logic [UPC_W-1:0] A_ADD   = 4'd9;
    localparam logic [UPC_W-1:0] A_MUL   = 4'd10;
    localparam logic [UPC_W-1:0] A_ABS   = 4'd11;
    localparam logic [UPC_W-1:0] A_RCP   = 4'd12;
    localparam logic [UPC_W-1:0] A_OUT   = 4'd13;
    localparam logic [UPC_W-1:0] A_RETRY = 4'd14;

    // ADC count at each 10 C point, -10 C first; unused slots read zero
    function automatic logic [ENTRY_W-1:0] ntcti_entry(input logic [SLOT_W-1:0] slot);
        logic [ENTRY_W-1:0] v;
        begin
            case (slot)
                5'd0:    v = 13'd4243;
                5'd1:    v = 13'd3836;
                5'd2:    v = 13'd3333;
                5'd3:    v = 13'd2779;
                5'd4:    v = 13'd2230;
                5'd5:    v = 13'd1735;
                5'd6:    v = 13'd1320;
                5'd7:    v = 13'd992;
                5'd8:    v = 13'd742;
                5'd9:    v = 13'd556;
                5'd10:   v = 13'd417;
                5'd11:   v = 13'd316;
                5'd12:   v = 13'd241;
                default: v = 13'd0;
            endcase
            return v;
        end
    endfunction

    // control store: jump to target when cond holds, else fall through
    function automatic ucode_t ntcti_ucode(input logic [UPC_W-1:0] addr);
        ucode_t w;
        begin
            case (addr)
                A_WAIT:  w = '{OP_LOAD,      C_NO_ACCEPT,   A_WAIT};
                A_CHK:   w = '{OP_NOP,       C_ABOVE_FIRST, A_CLLO};
                A_SCAN:  w = '{OP_NOP,       C_FOUND,       A_D1LD};
                A_STEP:  w = '{OP_INC,       C_NOT_LAST,    A_SCAN};
                A_CLHI:  w = '{OP_STAT_HI,   C_ALWAYS,      A_ADD};
                A_CLLO:  w = '{OP_STAT_LO,   C_ALWAYS,      A_ADD};
                A_D1LD:  w = '{OP_DIV1_LOAD, C_NEVER,       A_WAIT};
                A_D1:    w = '{OP_DIV_STEP,  C_DIV_MORE,    A_D1};
                A_TMF:   w = '{OP_TM_FRAC,   C_NEVER,       A_WAIT};
                A_ADD:   w = '{OP_ADD,       C_NEVER,       A_WAIT};
                A_MUL:   w = '{OP_MUL,       C_NEVER,       A_WAIT};
                A_ABS:   w = '{OP_ABS,       C_NEVER,       A_WAIT};
                A_RCP:   w = '{OP_RECIP,     C_NEVER,       A_WAIT};
                A_OUT:   w = '{OP_OUT,       C_OUT_FREE,    A_WAIT};
                A_RETRY: w = '{OP_NOP,       C_ALWAYS,      A_OUT};
                default: w = '{OP_NOP,       C_ALWAYS,      A_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

@@ rtl/core/ntc_table_temperature_interpolator.sv @@
// ntc_table_temperature_interpolator: top level, microcoded sequencer
// around a table scan, an iterative divider and three multipliers.
// Depends on ntcti_pkg and ntcti_div.
//
// Usage:
//   Input stream s_axis: one beat per ADC reading. Output stream m_axis:
//   one beat per reading, temperature in 0.01 C on tdata, range status
//   on tuser (0 interpolated, 1 clamped low, 2 clamped high).
//   Config port: cfg_wr_en/cfg_index/cfg_wr_data; index 0 temp_scale
//   (thousandths), index 1 temp_offset (millidegrees). Write while idle.
//   One item at a time. The table scan visits one entry per pass through its
//   scan and step states, and the divider retires one fraction bit per cycle;
//   the divide by 10000 is a shift and a reciprocal multiply. A reading above
//   the first entry clamps low at once; otherwise the scan ends in a segment,
//   which is divided for the fraction, or at the last entry (clamped high).
//   Then the offset is added, the scale multiplied, and the divide by 10000 done.
//   tready is high only while the sequencer waits; the next reading is taken
//   while a result still sits in the output register. A stalled receiver
//   holds the result; the sequencer alternates between its output and retry
//   steps and writes the next one once it drains. Reset clears the sequencer,
//   empties the output register, loads scale 1000, offset 0.
module ntc_table_temperature_interpolator
    import ntcti_pkg::*;
#(
    parameter int TABLE_ENTRIES = 13,
    parameter int ADC_BITS      = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] adc_reading
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] temperature
    output logic [1:0]  m_axis_tuser,   // [1:0] range_status
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wr_data
);

    localparam int RD_W  = (ADC_BITS < 12) ? ADC_BITS : 12;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int NUMP_W = ENTRY_W + DVSR_W;

    logic [UPC_W-1:0]        upc_reg, upc_next;
    ucode_t                  uw;
    logic                    accept;
    logic                    cond_ok;

    logic signed [15:0]      scale_reg;
    logic signed [15:0]      offset_reg;

    logic [RD_W-1:0]         reading_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [TM_W-1:0]  base_reg;
    logic signed [TM_W-1:0]  tm_reg;
    status_t                 status_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                    sign_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [QUO_W-1:0]        quo_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [15:0]             out_temp_reg;
    status_t                 out_status_reg;

    logic [ENTRY_W-1:0]      first_entry, cur_entry, prev_entry;
    logic [ENTRY_W-1:0]      reading_ext;
    logic [ENTRY_W-1:0]      num, span;
    logic [NUMP_W-1:0]       frac_dvnd;
    logic signed [PROD_W-1:0] prod_neg;
    logic [PROD_W-1:0]       prod_abs;
    logic [RCP_W-1:0]        rcp_prod;
    logic [15:0]             sat_temp;

    div_ctl_t                div_ctl;
    logic [DVND_W-1:0]       div_dvnd;
    logic [DVSR_W-1:0]       div_dvsr;
    logic [DIV_STEPS-1:0]    quotient;
    logic                    div_more;

    assign uw            = ntcti_ucode(upc_reg);
    assign s_axis_tready = upc_reg == A_WAIT;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign reading_ext = ENTRY_W'(reading_reg);
    assign first_entry = ntcti_entry('0);
    assign cur_entry   = ntcti_entry(SLOT_W'(idx_reg));
    assign prev_entry  = ntcti_entry(SLOT_W'(idx_reg - 1'b1));
    assign num         = prev_entry - reading_ext;
    assign span        = prev_entry - cur_entry;
    assign frac_dvnd   = NUMP_W'(num) * NUMP_W'(STEP_MILLI);
    assign prod_neg    = -prod_reg;
    assign prod_abs    = prod_reg[PROD_W-1] ? prod_neg : prod_reg;
    assign rcp_prod    = RCP_W'(mag_reg) * RCP_W'(RCP_MUL);

    always_comb
    begin
        case (uw.cond)
            C_NEVER:       cond_ok = 1'b0;
            C_ALWAYS:      cond_ok = 1'b1;
            C_NO_ACCEPT:   cond_ok = !accept;
            C_ABOVE_FIRST: cond_ok = reading_ext > first_entry;
            C_FOUND:       cond_ok = reading_ext > cur_entry;
            C_NOT_LAST:    cond_ok = idx_reg != IDX_W'(TABLE_ENTRIES - 1);
            C_DIV_MORE:    cond_ok = div_more;
            C_OUT_FREE:    cond_ok = !out_valid_reg;
            default:       cond_ok = 1'b0;
        endcase
        upc_next = cond_ok ? uw.target : upc_reg + 1'b1;
    end

    always_comb
    begin
        div_ctl.load = uw.op == OP_DIV1_LOAD;
        div_ctl.step = uw.op == OP_DIV_STEP;
        div_dvnd     = DVND_W'(frac_dvnd);
        div_dvsr     = DVSR_W'(span);
    end

    ntcti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dvnd),
        .divisor  (div_dvsr),
        .quotient (quotient),
        .more     (div_more)
    );

    // truncated quotient magnitude, signed and saturated to 16 bits
    always_comb
    begin
        if (sign_reg)
        begin
            sat_temp = (quo_reg > QUO_W'(32768)) ? 16'h8000
                                                 : 16'd0 - quo_reg[15:0];
        end
        else
        begin
            sat_temp = (quo_reg > QUO_W'(32767)) ? 16'h7FFF : quo_reg[15:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (uw.op == OP_OUT && !out_valid_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= A_WAIT;
            out_valid_reg <= 1'b0;
            scale_reg     <= 16'sd1000;
            offset_reg    <= 16'sd0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_TEMP_SCALE:  scale_reg  <= $signed(cfg_wr_data);
                    REG_TEMP_OFFSET: offset_reg <= $signed(cfg_wr_data);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (uw.op)
            OP_LOAD:
            begin
                if (accept)
                begin
                    reading_reg <= s_axis_tdata[RD_W-1:0];
                    idx_reg     <= IDX_W'(1);
                    base_reg    <= TM_W'(LOW_MILLI);
                end
            end
            OP_INC:
            begin
                idx_reg  <= idx_reg + 1'b1;
                base_reg <= base_reg + TM_W'(STEP_MILLI);
            end
            OP_STAT_HI:
            begin
                tm_reg     <= base_reg;
                status_reg <= ST_CLAMP_HI;
            end
            OP_STAT_LO:
            begin
                tm_reg     <= base_reg;
                status_reg <= ST_CLAMP_LO;
            end
            OP_TM_FRAC:
            begin
                tm_reg     <= base_reg + $signed({{(TM_W-FRAC_W){1'b0}}, quotient[FRAC_W-1:0]});
                status_reg <= ST_INTERP;
            end
            OP_ADD:
            begin
                sum_reg <= SUM_W'(tm_reg) + SUM_W'(offset_reg);
            end
            OP_MUL:
            begin
                prod_reg <= PROD_W'(sum_reg) * PROD_W'(scale_reg);
            end
            OP_ABS:
            begin
                sign_reg <= prod_reg[PROD_W-1];
                mag_reg  <= prod_abs[MAG_LSB+MAG_W-1:MAG_LSB];
            end
            OP_RECIP:
            begin
                quo_reg <= rcp_prod[RCP_W-1:RCP_SHIFT];
            end
            OP_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_temp_reg   <= sat_temp;
                    out_status_reg <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_temp_reg;
    assign m_axis_tuser  = out_status_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> upc_reg == A_CHK)
        else $error("accepted beat did not start the program");

    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg == A_TMF |-> quotient < DIV_STEPS'(STEP_MILLI))
        else $error("interpolation fraction out of range");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(upc_reg) == A_OUT)
        else $error("output loaded outside the output step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == OP_OUT && out_valid_reg && !m_axis_tready) |=> out_valid_reg)
        else $error("pending beat lost while sequencer waited");

endmodule

@@ rtl/core/ntcti_div.sv @@
// ntcti_div: restoring unsigned divider, one quotient bit per cycle while step is held.
// Depends on ntcti_pkg. Dividend must be below divisor << DIV_STEPS.
module ntcti_div
    import ntcti_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_ctl_t             ctl,
    input  logic [DVND_W-1:0]    dividend,
    input  logic [DVSR_W-1:0]    divisor,
    output logic [DIV_STEPS-1:0] quotient,
    output logic                 more
);

    logic [DVSR_W-1:0]    rem_reg;
    logic [DIV_STEPS-1:0] dq_reg;
    logic [DVSR_W-1:0]    dvsr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DVSR_W:0]      trial;
    logic [DVSR_W:0]      diff;
    logic                 ge;

    assign trial = {rem_reg, dq_reg[DIV_STEPS-1]};
    assign ge    = trial >= {1'b0, dvsr_reg};
    assign diff  = trial - {1'b0, dvsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.load)
        begin
            cnt_reg <= CNT_W'(DIV_STEPS);
        end
        else if (ctl.step && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg  <= dividend[DVND_W-1:DIV_STEPS];
            dq_reg   <= dividend[DIV_STEPS-1:0];
            dvsr_reg <= divisor;
        end
        else if (ctl.step)
        begin
            rem_reg <= ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
            dq_reg  <= {dq_reg[DIV_STEPS-2:0], ge};
        end
    end

    assign quotient = dq_reg;
    assign more     = cnt_reg != CNT_W'(1);

endmodule

@@ test/temperature_checker.sv @@
// temperature_checker: watches the reading, result and register ports of the NTC
// interpolator, predicts each result and compares it field by field.
// Depends on ntcti_pkg for the status codes, register indexes and table step constants.
module temperature_checker
    import ntcti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wr_data,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] temperature;
        status_t            status;
    } temp_result_t;

    localparam int KNOTS = 13;
    localparam int CURVE [0:KNOTS-1] = '{4243, 3836, 3333, 2779, 2230, 1735, 1320,
                                         992, 742, 556, 417, 316, 241};

    logic signed [15:0] gain_q;
    logic signed [15:0] bias_q;
    temp_result_t       expected_temps [$];
    temp_result_t       want;

    function automatic temp_result_t convert_reading(input logic [11:0] adc,
                                                     input logic signed [15:0] gain,
                                                     input logic signed [15:0] bias);
        temp_result_t r;
        int           seg;
        int           span;
        int           milli;
        logic         found;
        longint       prod;
        longint       quot;
        milli    = LOW_MILLI + (KNOTS - 1) * STEP_MILLI;
        r.status = ST_CLAMP_HI;
        if (int'(adc) > CURVE[0]) begin
            milli    = LOW_MILLI;
            r.status = ST_CLAMP_LO;
        end
        else begin
            found = 1'b0;
            seg   = 1;
            while (!found && seg < KNOTS) begin
                if (int'(adc) > CURVE[seg]) begin
                    span     = CURVE[seg-1] - CURVE[seg];
                    milli    = LOW_MILLI + (seg - 1) * STEP_MILLI
                               + ((CURVE[seg-1] - int'(adc)) * STEP_MILLI) / span;
                    r.status = ST_INTERP;
                    found    = 1'b1;
                end
                seg++;
            end
        end
        prod = (longint'(milli) + longint'(bias)) * longint'(gain);
        quot = prod / 10000;
        if (quot > 32767)
            quot = 32767;
        else if (quot < -32768)
            quot = -32768;
        r.temperature = quot[15:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            gain_q = 16'sd1000;
            bias_q = 16'sd0;
            expected_temps.delete();
            errors  = 0;
            pending = 0;
        end
        else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_TEMP_SCALE)
                    gain_q = cfg_wr_data;
                else
                    bias_q = cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_temps.push_back(convert_reading(s_axis_tdata[11:0], gain_q, bias_q));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_temps.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat, temperature %0d status %0d",
                             $time, $signed(m_axis_tdata), m_axis_tuser);
                end
                else begin
                    want = expected_temps.pop_front();
                    if (m_axis_tdata !== want.temperature) begin
                        errors++;
                        $display("%0t: temperature expected %0d actual %0d",
                                 $time, want.temperature, $signed(m_axis_tdata));
                    end
                    if (m_axis_tuser !== want.status) begin
                        errors++;
                        $display("%0t: range status expected %0d actual %0d",
                                 $time, want.status, m_axis_tuser);
                    end
                end
            end
            pending = expected_temps.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// tb_top: drives ADC readings and register writes into the NTC interpolator
// under random idling and a long output stall; temperature_checker scores it.
// Depends on ntcti_pkg, ntc_table_temperature_interpolator, temperature_checker.
module tb_top;
    import ntcti_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_TEMP_SCALE;
    logic [15:0] cfg_wr_data = 16'd0;
    int          errors;
    int          pending;
    int          cycle_count = 0;
    bit          gaps_on = 1'b1;
    bit          hold_req = 1'b0;

    int corner_readings [] = '{0, 1, 240, 241, 242, 316, 317, 417, 556, 742, 992, 1320,
                               1735, 2230, 2779, 3333, 3835, 3836, 3837, 4094, 4095,
                               2730, 1365};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ntc_table_temperature_interpolator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    temperature_checker temp_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .errors        (errors),
        .pending       (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else begin
                m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 34);
            end
        end
    end

    task automatic offer_reading(input logic [11:0] adc);
        while (gaps_on && $urandom_range(0, 99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, adc};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [11:0] pick_reading();
        int v;
        logic [4:0] knot;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 4095);
            4, 5, 6: begin
                knot = 5'($urandom_range(0, 12));
                v    = int'(ntcti_entry(knot)) + int'($urandom_range(0, 16)) - 8;
            end
            7:       v = $urandom_range(0, 245);
            8:       v = $urandom_range(3830, 4095);
            default: v = $urandom_range(0, 31) | ($urandom_range(0, 1) ? 4064 : 0);
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    task automatic run_readings(input int count);
        repeat (count) offer_reading(pick_reading());
        s_axis_tvalid <= 1'b0;
    endtask

    // registers change only once every result has drained
    task automatic write_settings(input logic [15:0] gain, input logic [15:0] bias);
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_TEMP_SCALE;
        cfg_wr_data <= gain;
        @(posedge clk);
        cfg_index   <= REG_TEMP_OFFSET;
        cfg_wr_data <= bias;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_readings[i])
            offer_reading(corner_readings[i][11:0]);
        s_axis_tvalid <= 1'b0;

        write_settings(16'sd32767, 16'sd32767);
        run_readings(140);
        write_settings(-16'sd32768, -16'sd32768);
        run_readings(140);
        write_settings(16'sd0, 16'sd12345);
        run_readings(60);
        write_settings(16'sd32767, -16'sd32768);
        gaps_on = 1'b0;
        run_readings(140);
        gaps_on = 1'b1;
        write_settings(-16'sd32768, 16'sd32767);
        hold_req = 1'b1;
        run_readings(140);
        repeat (4)
        begin
            write_settings(16'($urandom), 16'($urandom));
            run_readings(80);
        end
        write_settings(-16'sd1000, -16'sd5000);
        run_readings(100);
        write_settings(16'sd1000, 16'sd0);
        run_readings(100);

        do
            @(posedge clk);
        while (pending != 0);
        repeat (80) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ntcti_pkg.sv
rtl/core/ntcti_div.sv
rtl/core/ntc_table_temperature_interpolator.sv
test/temperature_checker.sv
test/tb_top.sv
